### sv/ascu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascu_pkg
// Shared constants, command/status structs and state type for the aging
// slot cache unit.
// ----------------------------------------------------------------------------
package ascu_pkg;

   localparam int SLOT_COUNT = 80;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int KEY_W      = 16;
   localparam int AGE_W      = 2;
   localparam int KIND_W     = 2;
   localparam int SLOT_W     = 7;
   localparam int ENTRY_W    = KEY_W + AGE_W;

   localparam logic [AGE_W-1:0]  FULL_AGE    = 2'd3;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic clear_all;
      logic rd_en;
      logic tick_wr;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic last_addr;
   } dp_stat_type;

endpackage

### sv/ascu_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascu_dpath
// Slot memory with per-slot valid bits, scan address counter, one-slot
// compare stage, search trackers and the result register.
// ----------------------------------------------------------------------------
module ascu_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  ascu_pkg::dp_cmd_type      cmd,
   output ascu_pkg::dp_stat_type     stat,
   input  logic [ascu_pkg::KEY_W-1:0] req_key,
   output logic [ascu_pkg::SLOT_W-1:0] res_slot,
   output logic                      res_hit,
   output logic                      res_load,
   output logic                      res_error
);
   import ascu_pkg::*;

   logic [ENTRY_W-1:0] slot_mem [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   slot_idx_type          addr_ff, addr_in;
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic                  rd_vld_ff;
   slot_idx_type          cmp_idx_ff;
   logic                  cmp_en_ff;
   logic [KEY_W-1:0]      key_ff, key_in;

   logic                  hit_found_ff, hit_found_in;
   logic                  empty_found_ff, empty_found_in;
   logic                  aged_found_ff, aged_found_in;
   slot_idx_type          hit_idx_ff, hit_idx_in;
   slot_idx_type          empty_idx_ff, empty_idx_in;
   slot_idx_type          aged_idx_ff, aged_idx_in;

   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  res_hit_ff, res_hit_in;
   logic                  res_load_ff, res_load_in;
   logic                  res_error_ff, res_error_in;

   logic [KEY_W-1:0]      ent_key;
   logic [AGE_W-1:0]      ent_age;
   slot_idx_type          pick_idx;
   logic                  pick_ok;
   logic                  wr_en;
   slot_idx_type          wr_addr;
   logic [ENTRY_W-1:0]    wr_data;

   // a slot that was never written since reset or clear reads as all zero
   assign ent_key = rd_vld_ff ? rd_data_ff[ENTRY_W-1:AGE_W] : '0;
   assign ent_age = rd_vld_ff ? rd_data_ff[AGE_W-1:0] : '0;

   assign pick_ok  = hit_found_ff | empty_found_ff | aged_found_ff;
   assign pick_idx = hit_found_ff   ? hit_idx_ff   :
                     empty_found_ff ? empty_idx_ff : aged_idx_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pick_idx;
      wr_data = {key_ff, FULL_AGE};
      if (cmd.commit && pick_ok) begin
         wr_en = 1'b1;
      end else if (cmd.tick_wr && cmp_en_ff && (ent_age != '0)) begin
         wr_en   = 1'b1;
         wr_addr = cmp_idx_ff;
         wr_data = {ent_key, ent_age - AGE_W'(1)};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.start) begin
         addr_in = '0;
      end else if (cmd.rd_en && !stat.last_addr) begin
         addr_in = addr_ff + slot_idx_type'(1);
      end
   end

   assign stat.last_addr = (addr_ff == slot_idx_type'(SLOT_COUNT - 1));
   assign key_in = cmd.start ? req_key : key_ff;

   always_comb begin
      hit_found_in   = hit_found_ff;
      empty_found_in = empty_found_ff;
      aged_found_in  = aged_found_ff;
      hit_idx_in     = hit_idx_ff;
      empty_idx_in   = empty_idx_ff;
      aged_idx_in    = aged_idx_ff;
      if (cmd.start) begin
         hit_found_in   = 1'b0;
         empty_found_in = 1'b0;
         aged_found_in  = 1'b0;
      end else if (cmp_en_ff) begin
         // keep the first slot of each kind in scan order
         if (!hit_found_ff && (ent_key == key_ff)) begin
            hit_found_in = 1'b1;
            hit_idx_in   = cmp_idx_ff;
         end
         if (!empty_found_ff && (ent_key == '0)) begin
            empty_found_in = 1'b1;
            empty_idx_in   = cmp_idx_ff;
         end
         if (!aged_found_ff && (ent_age == '0)) begin
            aged_found_in = 1'b1;
            aged_idx_in   = cmp_idx_ff;
         end
      end
   end

   always_comb begin
      res_slot_in  = res_slot_ff;
      res_hit_in   = res_hit_ff;
      res_load_in  = res_load_ff;
      res_error_in = res_error_ff;
      if (cmd.start) begin
         res_slot_in  = '0;
         res_hit_in   = 1'b0;
         res_load_in  = 1'b0;
         res_error_in = 1'b0;
      end else if (cmd.commit) begin
         res_slot_in  = pick_ok ? SLOT_W'(pick_idx) : '0;
         res_hit_in   = hit_found_ff;
         res_load_in  = pick_ok && !hit_found_ff;
         res_error_in = !pick_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= slot_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         cmp_en_ff <= 1'b0;
         addr_ff   <= '0;
      end else begin
         valid_ff  <= valid_in;
         cmp_en_ff <= cmd.rd_en;
         addr_ff   <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_vld_ff  <= valid_ff[addr_ff];
         cmp_idx_ff <= addr_ff;
      end
      key_ff         <= key_in;
      hit_found_ff   <= hit_found_in;
      empty_found_ff <= empty_found_in;
      aged_found_ff  <= aged_found_in;
      hit_idx_ff     <= hit_idx_in;
      empty_idx_ff   <= empty_idx_in;
      aged_idx_ff    <= aged_idx_in;
      res_slot_ff    <= res_slot_in;
      res_hit_ff     <= res_hit_in;
      res_load_ff    <= res_load_in;
      res_error_ff   <= res_error_in;
   end

   assign res_slot  = res_slot_ff;
   assign res_hit   = res_hit_ff;
   assign res_load  = res_load_ff;
   assign res_error = res_error_ff;

   // age write-back never collides with the slot being read
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (wr_en && cmd.rd_en) |-> (wr_addr != addr_ff))
      else $error("write-back hits the slot being read");

   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !cmp_en_ff && !cmd.rd_en)
      else $error("commit while scan still in flight");

   a_error_zero_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !pick_ok |=> res_error_ff && (res_slot_ff == '0) && !res_load_ff)
      else $error("error result carries a slot or load");

endmodule

### sv/ascu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascu_ctrl
// One-item sequencer: accept, scan (lookup/tick), commit (lookup), response.
// ----------------------------------------------------------------------------
module ascu_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ascu_pkg::KIND_W-1:0] req_kind,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output ascu_pkg::dp_cmd_type        cmd,
   input  ascu_pkg::dp_stat_type       stat
);
   import ascu_pkg::*;

   state_type          state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;

   assign kind_in = (state_ff == ST_IDLE && req_tvalid) ? req_kind : kind_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == KIND_LOOKUP || req_kind == KIND_TICK) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (stat.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = (kind_ff == KIND_LOOKUP) ? ST_WRITE : ST_RESP;
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.start     = req_tvalid;
            cmd.clear_all = req_tvalid && (req_kind == KIND_CLEAR);
         end
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.tick_wr = (kind_ff == KIND_TICK);
         end
         ST_DRAIN: begin
            cmd.tick_wr = (kind_ff == KIND_TICK);
         end
         ST_WRITE: begin
            cmd.commit = 1'b1;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_LOOKUP;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stat.last_addr) |=> state_ff == ST_DRAIN)
      else $error("scan did not end after the last slot");

   a_commit_lookup_only: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> kind_ff == KIND_LOOKUP)
      else $error("commit for an item that is not a lookup");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tready && rsp_tvalid) == 1'b0)
      else $error("input ready while a response is pending");

endmodule

### sv/aging_slot_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_slot_cache_unit
// Fully associative slot cache with 2-bit aging replacement.
// ----------------------------------------------------------------------------
// sequence: lookup runs scan, drain and write, then raises rsp_tvalid;
//   tick runs scan and drain only; clear and unused kinds go straight to the response
// throughput: one item at a time; the slot scan reads one memory entry per cycle
// reset: synchronous; clears the sequencer and the per-slot valid bits, so all
//   slots read as key 0 age 0 at once with no clearing pass
// ----------------------------------------------------------------------------
module aging_slot_cache_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] key
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] slot, [7] zero
   output logic [2:0]  rsp_tuser    // [0] hit, [1] load, [2] error
);
   import ascu_pkg::*;

   dp_cmd_type        cmd;
   dp_stat_type       stat;
   logic [SLOT_W-1:0] res_slot;
   logic              res_hit;
   logic              res_load;
   logic              res_error;

   ascu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   ascu_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_key   (req_tdata),
      .res_slot  (res_slot),
      .res_hit   (res_hit),
      .res_load  (res_load),
      .res_error (res_error)
   );

   assign rsp_tdata = {1'b0, res_slot};
   assign rsp_tuser = {res_error, res_load, res_hit};

endmodule

### verif/aging_slot_cache_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_slot_cache_unit_tb
// Self-checking bench for the aging slot cache: drives lookup, tick, clear and
// unused-kind transfers with bursty timing against a random-stalling receiver,
// and checks each response against an in-bench model of the slot keys and ages.
// ----------------------------------------------------------------------------
module aging_slot_cache_unit_tb;
   import ascu_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 600;
   localparam int RANDOM_ITEMS  = 430;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic              load;
      logic              error;
   } slot_result_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_PERIODIC,
      RX_SPARSE
   } rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] key
   logic [1:0]  req_tuser  = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [6:0] slot, [7] zero
   logic [2:0]  rsp_tuser;         // [0] hit, [1] load, [2] error

   logic [KEY_W-1:0] cache_keys [SLOT_COUNT];
   logic [AGE_W-1:0] cache_ages [SLOT_COUNT];

   slot_result_type pending_slot_results [$];
   int unsigned  fail_count   = 0;
   int unsigned  cycle_count  = 0;
   int unsigned  burst_left   = 0;
   bit           eager_sender = 1'b0;
   bit           hold_request = 1'b0;
   int unsigned  rx_cycle     = 0;
   int unsigned  rx_hold      = 0;
   rx_mode_type  rx_mode      = RX_OPEN;

   aging_slot_cache_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void clear_cache_model();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         cache_keys[i] = '0;
         cache_ages[i] = '0;
      end
   endfunction

   // updates the cache model and returns the response the transfer should cause
   function automatic slot_result_type next_slot_result(input logic [KIND_W-1:0] kind,
                                                        input logic [KEY_W-1:0] key);
      slot_result_type res;
      int pick;
      res  = '0;
      pick = -1;
      case (kind)
         KIND_LOOKUP: begin
            for (int i = 0; i < SLOT_COUNT && pick < 0; i++) begin
               if (cache_keys[i] == key) begin
                  pick    = i;
                  res.hit = 1'b1;
               end
            end
            for (int i = 0; i < SLOT_COUNT && pick < 0; i++) begin
               if (cache_keys[i] == '0) pick = i;
            end
            for (int i = 0; i < SLOT_COUNT && pick < 0; i++) begin
               if (cache_ages[i] == '0) pick = i;
            end
            if (pick < 0) begin
               res.error = 1'b1;
            end else begin
               if (!res.hit) begin
                  cache_keys[pick] = key;
                  res.load         = 1'b1;
               end
               cache_ages[pick] = FULL_AGE;
               res.slot         = SLOT_W'(pick);
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (cache_ages[i] != '0) cache_ages[i] = cache_ages[i] - 1'b1;
            end
         end
         KIND_CLEAR: begin
            clear_cache_model();
         end
         default: ;
      endcase
      return res;
   endfunction

   // receiver: ready pattern follows one of four randomly chosen modes, long hold-off on request
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      if (hold_request) begin
         rx_hold      = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (rx_hold != 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:     rsp_tready <= 1'b1;
            RX_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_tready <= (rx_cycle % 5 == 0);
            default:     rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      slot_result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_slot_results.size() == 0) begin
            $error("response transfer with no request outstanding: tdata %h tuser %b",
                   rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            exp = pending_slot_results.pop_front();
            if (rsp_tdata !== {1'b0, exp.slot}) begin
               $error("slot: expected %0d, got %0d", {1'b0, exp.slot}, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[0] !== exp.hit) begin
               $error("hit: expected %0b, got %0b", exp.hit, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== exp.load) begin
               $error("load: expected %0b, got %0b", exp.load, rsp_tuser[1]);
               fail_count++;
            end
            if (rsp_tuser[2] !== exp.error) begin
               $error("error: expected %0b, got %0b", exp.error, rsp_tuser[2]);
               fail_count++;
            end
         end
      end
   end

   // one request transfer; sender idles between bursts of random length
   task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
      int unsigned gap;
      if (burst_left == 0) begin
         if (eager_sender) gap = 0;
         else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 100);
         else gap = $urandom_range(0, 3);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      pending_slot_results.push_back(next_slot_result(kind, key));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_slot_results.size() != 0);
   endtask

   task automatic test_directed_cases();
      issue_request(KIND_LOOKUP, 16'h0000);   // key zero hits the empty slot
      issue_request(KIND_LOOKUP, 16'hFFFF);
      issue_request(KIND_LOOKUP, 16'hFFFF);
      issue_request(KIND_LOOKUP, 16'h0001);
      issue_request(KIND_LOOKUP, 16'h8000);
      issue_request(KIND_LOOKUP, 16'h0000);
      issue_request(KIND_LOOKUP, 16'h5555);
      issue_request(KIND_LOOKUP, 16'hAAAA);
      issue_request(KIND_TICK, 16'hFFFF);
      issue_request(KIND_UNUSED, 16'hAAAA);
      issue_request(KIND_LOOKUP, 16'h0001);
      issue_request(KIND_TICK, 16'h5555);
      issue_request(KIND_TICK, 16'h0000);
      issue_request(KIND_TICK, 16'hAAAA);
      issue_request(KIND_TICK, 16'h0000);     // ages already zero stay zero
      issue_request(KIND_LOOKUP, 16'h8000);
      issue_request(KIND_CLEAR, 16'h1234);
      issue_request(KIND_LOOKUP, 16'hFFFF);
      issue_request(KIND_LOOKUP, 16'h8000);
      issue_request(KIND_UNUSED, 16'h0000);
      issue_request(KIND_CLEAR, 16'hFFFF);
      issue_request(KIND_UNUSED, 16'hFFFF);
   endtask

   task automatic test_full_cache_eviction();
      issue_request(KIND_CLEAR, 16'h0000);
      for (int i = 0; i < SLOT_COUNT; i++) issue_request(KIND_LOOKUP, KEY_W'(16'h1000 + i));
      issue_request(KIND_LOOKUP, 16'h7777);   // full and all fresh: no slot
      issue_request(KIND_LOOKUP, 16'h1005);
      issue_request(KIND_TICK, 16'h0000);
      issue_request(KIND_LOOKUP, 16'h7777);
      issue_request(KIND_TICK, 16'h0000);
      issue_request(KIND_TICK, 16'h0000);
      issue_request(KIND_LOOKUP, 16'h7777);   // evicts first aged-out slot
      issue_request(KIND_LOOKUP, 16'h0000);   // key zero with no empty slot evicts too
      issue_request(KIND_LOOKUP, 16'h0000);
      issue_request(KIND_LOOKUP, 16'h1005);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_receiver_hold_off();
      wait_drain();
      hold_request = 1'b1;
      eager_sender = 1'b1;
      issue_request(KIND_LOOKUP, 16'h2222);
      issue_request(KIND_TICK, 16'h0000);
      issue_request(KIND_LOOKUP, 16'h2222);
      issue_request(KIND_LOOKUP, 16'h3333);
      issue_request(KIND_CLEAR, 16'h0000);
      issue_request(KIND_LOOKUP, 16'h3333);
      eager_sender = 1'b0;
      wait_drain();
   endtask

   // episodes over a key pool: small pools give hits, large ones fill and evict
   task automatic test_random_traffic(input int item_total);
      logic [KEY_W-1:0] key_pool [0:127];
      int  sent;
      int  pool_size;
      int  episode_len;
      int  roll;
      bit  big_pool;
      sent = 0;
      while (sent < item_total) begin
         big_pool  = ($urandom_range(0, 2) == 0);
         pool_size = big_pool ? $urandom_range(70, 120) : $urandom_range(2, 20);
         for (int i = 0; i < pool_size; i++) key_pool[i] = KEY_W'($urandom_range(0, 16'hFFFF));
         episode_len  = big_pool ? $urandom_range(100, 180) : $urandom_range(15, 50);
         eager_sender = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < episode_len && sent < item_total; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               issue_request(KIND_TICK, KEY_W'($urandom_range(0, 16'hFFFF)));
            end else if (roll < 10 && !big_pool) begin
               issue_request(KIND_CLEAR, KEY_W'($urandom_range(0, 16'hFFFF)));
            end else if (roll < 12) begin
               issue_request(KIND_UNUSED, KEY_W'($urandom_range(0, 16'hFFFF)));
               continue;
            end else if (roll < 14) begin
               issue_request(KIND_LOOKUP, 16'h0000);
            end else if (roll < 18) begin
               issue_request(KIND_LOOKUP, KEY_W'($urandom_range(0, 16'hFFFF)));
            end else begin
               issue_request(KIND_LOOKUP, key_pool[$urandom_range(0, pool_size - 1)]);
            end
            sent++;
         end
      end
      eager_sender = 1'b0;
   endtask

   initial begin
      clear_cache_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_cache_eviction();
      test_receiver_hold_off();
      test_random_traffic(RANDOM_ITEMS);
      wait_drain();
      repeat (SLOT_COUNT + 20) @(posedge clock);
      if (fail_count == 0 && pending_slot_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
